>>> sv/cssc_pkg.sv
// Shared constants, codes and transaction types for the column store scan counter.
`timescale 1ns / 1ps

package cssc_pkg;

    localparam int DEPTH   = 256;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int MATCH_W = 9;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CNT_EQ = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CNT_GT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CNT_LT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] operand_value;
        logic [POS_W-1:0]         position;
    } cssc_req_t;

    typedef struct packed {
        logic [MATCH_W-1:0]       match_count;
        logic signed [DATA_W-1:0] read_value;
        logic [STAT_W-1:0]        status;
    } cssc_rsp_t;

    // token passed cell to cell, one cell per cycle
    typedef struct packed {
        logic                     valid;
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] key;
        logic [IDX_W-1:0]         pos_idx;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] rdval;
        logic [STAT_W-1:0]        status;
    } cssc_tok_t;

endpackage

>>> sv/column_store_scan_counter.sv
// Top level: command intake, row of store cells and response register.
// The token of every command steps through the row of DEPTH cells, one cell per
// cycle, and its result is registered as the response. A new request is taken
// only when idle, after the previous result has entered the response register.
// Reset: control and the fill count clear to zero; entries are undefined
// until appended.
`timescale 1ns / 1ps

module column_store_scan_counter
    import cssc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  cssc_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output cssc_rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    cssc_rsp_t        rsp_reg, rsp_next;
    cssc_rsp_t        hold_reg, hold_next;
    cssc_tok_t        inject;
    cssc_tok_t        chain [DEPTH];
    cssc_tok_t        tail;
    cssc_rsp_t        result;
    logic             accept;
    logic             slot_free;

    assign accept    = req_valid && req_ready;
    assign req_ready = state_reg == ST_IDLE;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        inject         = '0;
        inject.valid   = accept;
        inject.cmd     = req.cmd;
        inject.key     = req.operand_value;
        inject.pos_idx = IDX_W'(req.position - POS_W'(1));
        inject.status  = STAT_OK;
        case (req.cmd) inside
            CMD_APPEND:
            begin
                if (fill_count_reg == CNT_W'(DEPTH))
                begin
                    inject.status = STAT_FULL;
                end
            end
            CMD_READ:
            begin
                if (req.position == '0 || CMP_W'(req.position) > CMP_W'(fill_count_reg))
                begin
                    inject.status = STAT_BADPOS;
                end
            end
            default:
            begin
                inject.status = STAT_OK;
            end
        endcase
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                cssc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cell_idx   (IDX_W'(k)),
                    .fill_count (fill_count_reg),
                    .tok_in     (inject),
                    .tok_out    (chain[k])
                );
            end
            else
            begin : g_body
                cssc_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .cell_idx   (IDX_W'(k)),
                    .fill_count (fill_count_reg),
                    .tok_in     (chain[k-1]),
                    .tok_out    (chain[k])
                );
            end
        end
    endgenerate

    assign tail = chain[DEPTH-1];

    always_comb
    begin
        result.match_count = MATCH_W'(tail.count);
        result.read_value  = tail.rdval;
        result.status      = tail.status;

        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        hold_next       = hold_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    if (tail.cmd == CMD_APPEND && tail.status == STAT_OK)
                    begin
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                    if (slot_free)
                    begin
                        rsp_next       = result;
                        rsp_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        hold_next  = result;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_SCAN)
        else $error("request transaction did not start a scan");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == ST_SCAN)
        else $error("token left the cell row outside a scan");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_count_reg) <= CMP_W'(DEPTH))
        else $error("fill count beyond store depth");

    a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HOLD |-> rsp_valid_reg)
        else $error("result held while response slot empty");

endmodule

>>> sv/cssc_cell.sv
// One cell of the store: holds a single entry and updates the passing token.
`timescale 1ns / 1ps

module cssc_cell
    import cssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic [CNT_W-1:0] fill_count,
    input  cssc_tok_t        tok_in,
    output cssc_tok_t        tok_out
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    cssc_tok_t                tok_reg;
    cssc_tok_t                tok_next;
    logic                     in_use;
    logic                     hit;

    always_comb
    begin
        in_use = CNT_W'(cell_idx) < fill_count;
        case (tok_in.cmd)
            CMD_CNT_EQ: hit = entry_reg == tok_in.key;
            CMD_CNT_GT: hit = entry_reg > tok_in.key;
            CMD_CNT_LT: hit = entry_reg < tok_in.key;
            default:    hit = 1'b0;
        endcase

        tok_next = tok_in;
        if (tok_in.valid && in_use && hit)
        begin
            tok_next.count = tok_in.count + CNT_W'(1);
        end
        if (tok_in.valid && tok_in.cmd == CMD_READ && tok_in.status == STAT_OK &&
            cell_idx == tok_in.pos_idx)
        begin
            tok_next.rdval = entry_reg;
        end

        entry_next = entry_reg;
        if (tok_in.valid && tok_in.cmd == CMD_APPEND && tok_in.status == STAT_OK &&
            CNT_W'(cell_idx) == fill_count)
        begin
            entry_next = tok_in.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;

endmodule

>>> tb/tb_column_store_scan_counter.sv
// Self-checking testbench for the column store scan counter: directed and random commands.
`timescale 1ns / 1ps

module tb_column_store_scan_counter;
    import cssc_pkg::*;

    localparam int NUM_RANDOM = 1830;
    localparam int DRAIN_AT   = 700;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 1200;
    localparam int QUIET_TAIL = 150;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    class scan_scoreboard;
        logic signed [DATA_W-1:0] column [DEPTH];
        int                       fill;
        cssc_rsp_t                expected_rsp [$];
        int                       mismatches;
        int                       results_seen;

        function new();
            fill         = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_request(cssc_req_t r);
            cssc_rsp_t                e;
            logic signed [DATA_W-1:0] key;
            int                       hits;
            e    = '0;
            key  = r.operand_value;
            hits = 0;
            case (r.cmd)
                CMD_APPEND:
                begin
                    if (fill >= DEPTH)
                        e.status = STAT_FULL;
                    else
                    begin
                        column[fill] = key;
                        fill++;
                    end
                end
                CMD_CNT_EQ, CMD_CNT_GT, CMD_CNT_LT:
                begin
                    for (int k = 0; k < fill; k++)
                    begin
                        if ((r.cmd == CMD_CNT_EQ && column[k] == key) ||
                            (r.cmd == CMD_CNT_GT && column[k] > key) ||
                            (r.cmd == CMD_CNT_LT && column[k] < key))
                            hits++;
                    end
                    e.match_count = MATCH_W'(hits);
                end
                CMD_READ:
                begin
                    if (r.position >= 1 && r.position <= fill)
                        e.read_value = column[r.position - 1];
                    else
                        e.status = STAT_BADPOS;
                end
                default: ;
            endcase
            expected_rsp.push_back(e);
        endfunction

        function void check_response(cssc_rsp_t got);
            cssc_rsp_t e;
            results_seen++;
            if (expected_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: count=%0d value=%0d status=%0d",
                             got.match_count, got.read_value, got.status);
                return;
            end
            e = expected_rsp.pop_front();
            if (got.match_count !== e.match_count || got.read_value !== e.read_value ||
                got.status !== e.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: exp count=%0d value=%0d status=%0d,",
                              " got count=%0d value=%0d status=%0d"},
                             e.match_count, e.read_value, e.status,
                             got.match_count, got.read_value, got.status);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    cssc_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    cssc_rsp_t rsp;

    scan_scoreboard           sb = new();
    bit                       idle_on = 1'b1;
    bit                       held_off = 1'b0;
    int                       appends_issued = 0;
    logic signed [DATA_W-1:0] appended [$];

    column_store_scan_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return DATA_W'(int'($urandom_range(0, 6)) - 3);
        else if (sel < 5 && appended.size() > 0)
            return appended[$urandom_range(0, appended.size() - 1)];
        else if (sel < 6)
            return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        else if (sel < 7 && appended.size() > 0)
            return appended[$urandom_range(0, appended.size() - 1)] +
                   ($urandom_range(0, 1) ? 1 : -1);
        else
            return $urandom();
    endfunction

    function automatic cssc_req_t random_command();
        cssc_req_t r;
        int        roll;
        int        sel;
        int        filled;
        filled          = (appends_issued < DEPTH) ? appends_issued : DEPTH;
        r.cmd           = CMD_APPEND;
        r.operand_value = $urandom();
        r.position      = POS_W'($urandom_range(0, DEPTH));
        roll            = $urandom_range(0, 99);
        if (roll < 25)
            r.operand_value = pick_value();
        else if (roll < 70)
        begin
            case ($urandom_range(0, 2))
                0:       r.cmd = CMD_CNT_EQ;
                1:       r.cmd = CMD_CNT_GT;
                default: r.cmd = CMD_CNT_LT;
            endcase
            r.operand_value = pick_value();
        end
        else if (roll < 95)
        begin
            r.cmd = CMD_READ;
            sel   = $urandom_range(0, 6);
            if (sel < 4 && filled > 0)
                r.position = POS_W'($urandom_range(1, filled));
            else if (sel == 4)
                r.position = '0;
            else if (sel == 5)
                r.position = POS_W'((filled < DEPTH) ? filled + 1 : DEPTH);
            else if (sel == 6)
                r.position = POS_W'(DEPTH);
        end
        else
            r.cmd = CMD_RSVD_LO + CMD_W'($urandom_range(0, 2));
        return r;
    endfunction

    task automatic send_item(cssc_req_t r);
        if (r.cmd == CMD_APPEND)
        begin
            if (appends_issued < DEPTH)
                appended.push_back(r.operand_value);
            appends_issued++;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic maybe_gap();
        int n;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val,
                         logic [POS_W-1:0] pos);
        cssc_req_t r;
        r.cmd           = cmd;
        r.operand_value = val;
        r.position      = pos;
        maybe_gap();
        send_item(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
    endtask

    // receiver: short random stalls, one long hold-off to back the block up
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && sb.results_seen >= HOLD_AT)
            begin
                held_off = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 3) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin
        #25_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store
        issue(CMD_CNT_EQ, '0, 9'd17);
        issue(CMD_READ, $urandom(), 9'd1);
        issue(CMD_READ, $urandom(), 9'd0);
        // extremes and neighbours of zero
        issue(CMD_APPEND, VAL_MIN, 9'd256);
        issue(CMD_APPEND, VAL_MAX, 9'd0);
        issue(CMD_APPEND, -1, 9'd255);
        issue(CMD_APPEND, 0, 9'd1);
        issue(CMD_APPEND, 1, 9'd128);
        // signed comparisons
        issue(CMD_CNT_EQ, -1, 9'd0);
        issue(CMD_CNT_GT, 0, 9'd0);
        issue(CMD_CNT_LT, 0, 9'd0);
        issue(CMD_CNT_GT, VAL_MIN, 9'd0);
        issue(CMD_CNT_LT, VAL_MAX, 9'd0);
        issue(CMD_CNT_LT, VAL_MIN, 9'd0);
        issue(CMD_CNT_GT, VAL_MAX, 9'd0);
        issue(CMD_CNT_EQ, VAL_MIN, 9'd0);
        // reads in and out of range
        issue(CMD_READ, 0, 9'd1);
        issue(CMD_READ, VAL_MAX, 9'd5);
        issue(CMD_READ, VAL_MIN, 9'd6);
        issue(CMD_READ, -1, 9'd256);
        issue(CMD_READ, 0, 9'd0);
        // unused codes
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++)
            issue(CMD_W'(c), $urandom(), 9'd256);

        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (i >= NUM_RANDOM - QUIET_TAIL)
                idle_on = 1'b0;
            if (i == DRAIN_AT)
                wait_drained();
            maybe_gap();
            send_item(random_command());
        end

        wait_drained();
        repeat (DEPTH + 50) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> column_store_scan_counter.f
sv/cssc_pkg.sv
sv/cssc_cell.sv
sv/column_store_scan_counter.sv
tb/tb_column_store_scan_counter.sv
